[rtl/core/double_ended_queue_core_defines.svh]
// Assertion macros shared by the deque RTL.
`ifndef DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

// property must hold at every edge out of reset
`define DEQ_CHK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen out of reset
`define DEQ_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[rtl/core/deq_pkg.sv]
`default_nettype none
package deq_pkg;

	localparam int DEPTH = 32;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [2:0]       opcode_t;
	typedef logic [1:0]       status_t;

	localparam logic [IDX_W:0] RING_LEN = (IDX_W + 1)'(DEPTH);
	localparam cnt_t CNT_FULL = CNT_W'(DEPTH);
	localparam idx_t IDX_TOP = IDX_W'(DEPTH - 1);

	localparam opcode_t OP_PUSH_FRONT = 3'd0;
	localparam opcode_t OP_PUSH_REAR  = 3'd1;
	localparam opcode_t OP_POP_FRONT  = 3'd2;
	localparam opcode_t OP_POP_REAR   = 3'd3;
	localparam opcode_t OP_DUMP       = 3'd4;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	typedef struct packed {
		logic    en;        // commit a push or pop to the pointers
		opcode_t opcode;
		logic    dump;      // address comes from the dump walk
		idx_t    dump_idx;
	} ptr_req_t;

	typedef struct packed {
		logic empty;
		logic full;
		idx_t addr;
		idx_t last_idx;     // offset of the rear element
	} ptr_stat_t;

	// both operands below DEPTH, so one conditional subtract wraps
	function automatic idx_t ring_add(idx_t base, idx_t off);
		logic [IDX_W:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= RING_LEN)
			s = s - RING_LEN;
		return s[IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

[rtl/core/deq_ptr.sv]
`default_nettype none
`include "double_ended_queue_core_defines.svh"
module deq_ptr (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire deq_pkg::ptr_req_t req,
	output deq_pkg::ptr_stat_t stat
);
	import deq_pkg::*;

	idx_t front_q;
	cnt_t count_q;
	idx_t front_dec;
	idx_t cnt_lo;
	idx_t cnt_m1;
	cnt_t cnt_m1_full;

	assign front_dec   = (front_q == '0) ? IDX_TOP : front_q - IDX_W'(1);
	assign cnt_lo      = count_q[IDX_W-1:0];
	assign cnt_m1_full = count_q - CNT_W'(1);
	assign cnt_m1      = cnt_m1_full[IDX_W-1:0];

	always_comb begin
		stat.empty    = (count_q == '0);
		stat.full     = (count_q == CNT_FULL);
		stat.last_idx = cnt_m1;
		if (req.dump) begin
			stat.addr = ring_add(front_q, req.dump_idx);
		end else begin
			case (req.opcode)
				OP_PUSH_FRONT: stat.addr = front_dec;
				OP_PUSH_REAR:  stat.addr = ring_add(front_q, cnt_lo);
				OP_POP_FRONT:  stat.addr = front_q;
				OP_POP_REAR:   stat.addr = ring_add(front_q, cnt_m1);
				default:       stat.addr = front_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (req.en) begin
			case (req.opcode)
				OP_PUSH_FRONT: begin
					front_q <= front_dec;
					count_q <= count_q + CNT_W'(1);
				end
				OP_PUSH_REAR: begin
					count_q <= count_q + CNT_W'(1);
				end
				OP_POP_FRONT: begin
					front_q <= ring_add(front_q, IDX_W'(1));
					count_q <= cnt_m1_full;
				end
				OP_POP_REAR: begin
					count_q <= cnt_m1_full;
				end
				default: begin
				end
			endcase
		end
	end

	`DEQ_NEVER(a_cnt_bound, count_q > CNT_FULL, "element count beyond depth")
	`DEQ_NEVER(a_push_full,
		req.en && (req.opcode == OP_PUSH_FRONT || req.opcode == OP_PUSH_REAR) && stat.full,
		"push committed into full queue")
	`DEQ_NEVER(a_pop_empty,
		req.en && (req.opcode == OP_POP_FRONT || req.opcode == OP_POP_REAR) && stat.empty,
		"pop committed from empty queue")

endmodule
`default_nettype wire

[rtl/core/double_ended_queue_core.sv]
// channel | direction | handshake            | payload
// in      | sink      | in_valid / in_stall   | opcode, value
// out     | source    | out_valid / out_stall | data, status, last
//
// Push: result registered the next cycle. Pop: the registered read of the element
// RAM comes before the output load. Dump: per stored element, a RAM read, then an
// output load; an empty dump loads its ST_EMPTY result directly.
// Reset clears pointers and count at once; the RAM is not cleared.
// in_stall is high while a pop or dump is in flight or the output register
// holds a transaction that out_stall is holding back.
`default_nettype none
`include "double_ended_queue_core_defines.svh"
module double_ended_queue_core (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire deq_pkg::opcode_t      opcode,
	input  wire logic signed [31:0]    value,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [31:0]         data,
	output deq_pkg::status_t           status,
	output logic                       last
);
	import deq_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_POP  = 2'd1;
	localparam logic [1:0] S_DRD  = 2'd2;
	localparam logic [1:0] S_DOUT = 2'd3;

	logic [1:0] state_q;
	idx_t       dump_idx_q;

	logic               out_valid_q;
	logic signed [31:0] data_q;
	status_t            status_q;
	logic               last_q;

	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;

	ptr_req_t  req;
	ptr_stat_t stat;

	logic in_go, out_free;
	logic is_push, is_pop, is_dump;
	logic do_push, do_pop;
	logic mem_re;
	logic dump_last;
	logic load_out;

	assign is_push = opcode inside {OP_PUSH_FRONT, OP_PUSH_REAR};
	assign is_pop  = opcode inside {OP_POP_FRONT, OP_POP_REAR};
	assign is_dump = (opcode == OP_DUMP);

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign in_go    = in_valid && !in_stall;

	assign do_push   = in_go && is_push && !stat.full;
	assign do_pop    = in_go && is_pop && !stat.empty;
	assign mem_re    = do_pop || (state_q == S_DRD);
	assign dump_last = (dump_idx_q == stat.last_idx);

	always_comb begin
		req.en       = do_push || do_pop;
		req.opcode   = opcode;
		req.dump     = (state_q == S_DRD);
		req.dump_idx = dump_idx_q;
	end

	// output register gets a new transaction this cycle
	always_comb begin
		case (state_q)
			S_IDLE:  load_out = in_go && (is_push || ((is_pop || is_dump) && stat.empty));
			S_POP:   load_out = 1'b1;
			S_DOUT:  load_out = out_free;
			default: load_out = 1'b0;
		endcase
	end

	deq_ptr u_ptr (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.stat   (stat)
	);

	always_ff @(posedge clk) begin
		if (do_push)
			mem[stat.addr] <= value;
		if (mem_re)
			rdata_q <= mem[stat.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dump_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_go && (is_pop || is_dump) && !stat.empty) begin
						if (is_pop) begin
							state_q <= S_POP;
						end else begin
							dump_idx_q <= '0;
							state_q    <= S_DRD;
						end
					end
				end
				S_POP: begin
					state_q <= S_IDLE;
				end
				S_DRD: begin
					state_q <= S_DOUT;
				end
				S_DOUT: begin
					if (out_free) begin
						if (dump_last) begin
							state_q <= S_IDLE;
						end else begin
							dump_idx_q <= dump_idx_q + IDX_W'(1);
							state_q    <= S_DRD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload of the output register, loaded with out_valid_q and on every accepted request
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_go) begin
					data_q <= '0;
					last_q <= 1'b1;
					if (is_push)
						status_q <= stat.full ? ST_FULL : ST_OK;
					else
						status_q <= ST_EMPTY;
				end
			end
			S_POP: begin
				data_q   <= rdata_q;
				status_q <= ST_OK;
				last_q   <= 1'b1;
			end
			S_DOUT: begin
				if (out_free) begin
					data_q   <= rdata_q;
					status_q <= ST_OK;
					last_q   <= dump_last;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign data      = data_q;
	assign status    = status_q;
	assign last      = last_q;

	`DEQ_CHK(a_pop_slot_free, (state_q == S_POP) |-> !out_valid_q,
		"pop result would overwrite pending transaction")
	`DEQ_CHK(a_full_refused,
		(in_go && is_push && stat.full) |=> (out_valid_q && status_q == ST_FULL && last_q),
		"full push not refused")
	`DEQ_CHK(a_empty_report,
		(in_go && (is_pop || is_dump) && stat.empty)
			|=> (out_valid_q && status_q == ST_EMPTY && data_q == '0),
		"empty queue not reported")
	`DEQ_CHK(a_dump_ends_idle,
		(state_q == S_DOUT && out_free && dump_last) |=> (state_q == S_IDLE && last_q),
		"dump did not end on rear element")

endmodule
`default_nettype wire
